@@ hw/rtl/grid_range_bound_query_defines.svh @@
// assertion macros shared by the grid range bound query rtl
// needs clk_i and rst_ni in the scope where the macros are used
`ifndef GRID_RANGE_BOUND_QUERY_DEFINES_SVH
`define GRID_RANGE_BOUND_QUERY_DEFINES_SVH

// same-cycle implication, off during reset
`define GRBQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grbq assertion failed");

// next-cycle implication, off during reset
`define GRBQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grbq assertion failed");

`endif

@@ hw/rtl/grbq_pkg.sv @@
// shared constants for the grid range bound query block
// no dependencies
package grbq_pkg;

  localparam int unsigned FIELD_W      = 24;
  localparam int unsigned SIZE_W       = 6;
  localparam int unsigned CELL_INDEX_W = 15;
  localparam int unsigned APB_ADDR_W   = 4;
  localparam int unsigned APB_DATA_W   = 32;

  localparam int unsigned MAX_DIM_DEF    = 32;
  localparam int unsigned VALUE_BITS_DEF = 24;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // register indexes
  localparam logic [1:0] REG_GRID_PRESENT = 2'd0;
  localparam logic [1:0] REG_SIZE_X       = 2'd1;
  localparam logic [1:0] REG_SIZE_Y       = 2'd2;
  localparam logic [1:0] REG_SIZE_Z       = 2'd3;

endpackage

@@ hw/rtl/grid_range_bound_query.sv @@
// grid range bound query: cell store in one synchronous memory, box walk and reduction
// depends on grbq_pkg and grid_range_bound_query_defines.svh
//
//   channel | direction | handshake                    | payload
//   in      | input     | in_valid_i / in_stall_o      | operation, cell_index, lo_*, hi_*, occupied
//   out     | output    | out_valid_o / out_stall_i    | min_*, max_*, empty_res
//   cfg     | input     | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// a write request leaves the request channel free; a query walks the covered cells through
// the single memory read port, one cell a cycle except for a row-base step per plane
// after reset a clearing pass zeroes all MAX_DIM**3 cells of the store (32768 at the default),
// during which no request is taken; configuration writes are taken at any time
// a result waits in the output register while out_stall_i is high; the next request is
// still taken, and a query that finishes meanwhile holds until the register frees up
`include "grid_range_bound_query_defines.svh"

module grid_range_bound_query
  import grbq_pkg::*;
#(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        operation_i,
  input  logic [CELL_INDEX_W-1:0]     cell_index_i,
  input  logic signed [FIELD_W-1:0]   lo_x_i,
  input  logic signed [FIELD_W-1:0]   lo_y_i,
  input  logic signed [FIELD_W-1:0]   lo_z_i,
  input  logic signed [FIELD_W-1:0]   hi_x_i,
  input  logic signed [FIELD_W-1:0]   hi_y_i,
  input  logic signed [FIELD_W-1:0]   hi_z_i,
  input  logic                        occupied_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [FIELD_W-1:0]   min_x_o,
  output logic signed [FIELD_W-1:0]   min_y_o,
  output logic signed [FIELD_W-1:0]   min_z_o,
  output logic signed [FIELD_W-1:0]   max_x_o,
  output logic signed [FIELD_W-1:0]   max_y_o,
  output logic signed [FIELD_W-1:0]   max_z_o,
  output logic                        empty_res_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_W-1:0]       paddr,
  input  logic [APB_DATA_W-1:0]       pwdata,
  output logic [APB_DATA_W-1:0]       prdata,
  output logic                        pready
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned VB    = VALUE_BITS;
  localparam int unsigned EW    = (VB > FIELD_W) ? VB : FIELD_W;

  typedef struct packed {
    logic                 occ;
    logic signed [VB-1:0] max_z;
    logic signed [VB-1:0] max_y;
    logic signed [VB-1:0] max_x;
    logic signed [VB-1:0] min_z;
    logic signed [VB-1:0] min_y;
    logic signed [VB-1:0] min_x;
  } cell_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_PLANE, S_ROW, S_WALK, S_DRAIN, S_DONE
  } state_e;

  function automatic logic signed [VB-1:0] to_store(input logic signed [FIELD_W-1:0] v);
    logic signed [EW-1:0] w;
    w = EW'(v);
    return w[VB-1:0];
  endfunction

  function automatic logic signed [FIELD_W-1:0] to_field(input logic signed [VB-1:0] v);
    logic signed [EW-1:0] w;
    w = EW'(v);
    return w[FIELD_W-1:0];
  endfunction

  function automatic logic [DW-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [DW-1:0] r;
    if (s == '0) begin
      r = DW'(1);
    end else if (32'(s) > MAX_DIM) begin
      r = DW'(MAX_DIM);
    end else begin
      r = DW'(s);
    end
    return r;
  endfunction

  // v is already sign-extended by one bit; negative goes to cell zero
  function automatic logic [CW-1:0] to_cell(input logic signed [FIELD_W:0] v,
                                            input logic [DW-1:0] sz);
    logic [FIELD_W-8:0] c;
    logic [CW-1:0]      r;
    c = v[FIELD_W:8];
    if (v[FIELD_W]) begin
      r = '0;
    end else if (32'(c) >= 32'(sz)) begin
      r = CW'(sz - DW'(1));
    end else begin
      r = CW'(c);
    end
    return r;
  endfunction

  // configuration registers
  logic              grid_present_q;
  logic [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_present_q <= 1'b0;
      size_x_q       <= SIZE_RESET;
      size_y_q       <= SIZE_RESET;
      size_z_q       <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GRID_PRESENT: grid_present_q <= pwdata[0];
        REG_SIZE_X:       size_x_q       <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:       size_y_q       <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:       size_z_q       <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GRID_PRESENT: prdata = {{(APB_DATA_W-1){1'b0}}, grid_present_q};
      REG_SIZE_X:       prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, size_x_q};
      REG_SIZE_Y:       prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, size_y_q};
      REG_SIZE_Z:       prdata = {{(APB_DATA_W-SIZE_W){1'b0}}, size_z_q};
      default:          prdata = '0;
    endcase
  end

  // control and datapath registers
  state_e                state_q;
  logic [AW-1:0]         clr_q;
  logic signed [FIELD_W-1:0] qlo_q [3];
  logic signed [FIELD_W-1:0] qhi_q [3];
  logic                  qpres_q;
  logic [DW-1:0]         sx_q;
  logic [AW-1:0]         sxsy_q;
  logic [2:0][CW-1:0]    cmin_q, cmax_q;
  logic [CW-1:0]         walk_i_q, walk_j_q, walk_k_q;
  logic [AW-1:0]         plane_q, row_q;
  logic                  rd_vld_q;
  cell_t                 rd_data_q;
  logic signed [VB-1:0]  acc_min_q [3];
  logic signed [VB-1:0]  acc_max_q [3];
  logic                  acc_occ_q;
  logic                  out_valid_q;

  // memory ports
  cell_t         mem [DEPTH];
  logic          wr_en, rd_en, in_acc, wr_in_range;
  logic [AW-1:0] wr_addr, rd_addr;
  cell_t         wr_data;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign wr_in_range = (32'(cell_index_i) < DEPTH);
  assign wr_en       = (state_q == S_CLEAR) ||
                       (in_acc && (operation_i == OP_WRITE) && wr_in_range);
  assign wr_addr     = (state_q == S_CLEAR) ? clr_q : AW'(cell_index_i);
  assign rd_en       = (state_q == S_WALK);
  assign rd_addr     = row_q + AW'(walk_i_q);

  always_comb begin
    if (state_q == S_CLEAR) begin
      wr_data = '0;
    end else begin
      wr_data.occ   = occupied_i;
      wr_data.min_x = to_store(lo_x_i);
      wr_data.min_y = to_store(lo_y_i);
      wr_data.min_z = to_store(lo_z_i);
      wr_data.max_x = to_store(hi_x_i);
      wr_data.max_y = to_store(hi_y_i);
      wr_data.max_z = to_store(hi_z_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // setup arithmetic
  logic [DW-1:0]      eff_sz [3];
  logic [2*DW-1:0]    sxsy_prod;
  logic [CW+AW-1:0]   plane_prod;
  logic [CW+DW-1:0]   row_prod;
  logic [2:0][CW-1:0] cmin_d, cmax_d;
  logic               box_void;
  logic signed [VB-1:0] rd_min [3];
  logic signed [VB-1:0] rd_max [3];

  assign eff_sz[0]  = eff_size(size_x_q);
  assign eff_sz[1]  = eff_size(size_y_q);
  assign eff_sz[2]  = eff_size(size_z_q);
  assign sxsy_prod  = eff_sz[0] * eff_sz[1];
  assign plane_prod = cmin_q[2] * sxsy_q;
  assign row_prod   = walk_j_q * sx_q;
  assign box_void   = (cmin_q[0] > cmax_q[0]) || (cmin_q[1] > cmax_q[1]) ||
                      (cmin_q[2] > cmax_q[2]);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cmin_d[a] = to_cell({qlo_q[a][FIELD_W-1], qlo_q[a]}, eff_sz[a]);
      cmax_d[a] = to_cell($signed({qhi_q[a][FIELD_W-1], qhi_q[a]}) + 25'sd128, eff_sz[a]);
    end
  end

  assign rd_min[0] = rd_data_q.min_x;
  assign rd_min[1] = rd_data_q.min_y;
  assign rd_min[2] = rd_data_q.min_z;
  assign rd_max[0] = rd_data_q.max_x;
  assign rd_max[1] = rd_data_q.max_y;
  assign rd_max[2] = rd_data_q.max_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      qpres_q     <= 1'b0;
      sx_q        <= '0;
      sxsy_q      <= '0;
      cmin_q      <= '0;
      cmax_q      <= '0;
      walk_i_q    <= '0;
      walk_j_q    <= '0;
      walk_k_q    <= '0;
      plane_q     <= '0;
      row_q       <= '0;
      rd_vld_q    <= 1'b0;
      acc_occ_q   <= 1'b0;
      out_valid_q <= 1'b0;
      min_x_o     <= '0;
      min_y_o     <= '0;
      min_z_o     <= '0;
      max_x_o     <= '0;
      max_y_o     <= '0;
      max_z_o     <= '0;
      empty_res_o <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        qlo_q[a]     <= '0;
        qhi_q[a]     <= '0;
        acc_min_q[a] <= '0;
        acc_max_q[a] <= '0;
      end
    end else begin
      rd_vld_q <= rd_en;

      // a finishing query reloads the register itself
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // reduce the cell that came back from the memory
      if (rd_vld_q) begin
        for (int a = 0; a < 3; a++) begin
          if (rd_min[a] < acc_min_q[a]) acc_min_q[a] <= rd_min[a];
          if (rd_max[a] > acc_max_q[a]) acc_max_q[a] <= rd_max[a];
        end
        if (rd_data_q.occ) acc_occ_q <= 1'b1;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (operation_i == OP_QUERY)) begin
            qlo_q[0] <= lo_x_i;
            qlo_q[1] <= lo_y_i;
            qlo_q[2] <= lo_z_i;
            qhi_q[0] <= hi_x_i;
            qhi_q[1] <= hi_y_i;
            qhi_q[2] <= hi_z_i;
            for (int a = 0; a < 3; a++) begin
              acc_min_q[a] <= '0;
              acc_max_q[a] <= '0;
            end
            acc_occ_q <= 1'b0;
            state_q   <= S_SETUP;
          end
        end
        S_SETUP: begin
          qpres_q <= grid_present_q;
          sx_q    <= eff_sz[0];
          sxsy_q  <= AW'(sxsy_prod);
          cmin_q  <= cmin_d;
          cmax_q  <= cmax_d;
          state_q <= grid_present_q ? S_PLANE : S_DONE;
        end
        S_PLANE: begin
          plane_q  <= AW'(plane_prod);
          walk_i_q <= cmin_q[0];
          walk_j_q <= cmin_q[1];
          walk_k_q <= cmin_q[2];
          state_q  <= box_void ? S_DONE : S_ROW;
        end
        S_ROW: begin
          row_q   <= plane_q + AW'(row_prod);
          state_q <= S_WALK;
        end
        S_WALK: begin
          if (walk_i_q != cmax_q[0]) begin
            walk_i_q <= walk_i_q + CW'(1);
          end else if (walk_j_q != cmax_q[1]) begin
            walk_i_q <= cmin_q[0];
            walk_j_q <= walk_j_q + CW'(1);
            row_q    <= row_q + AW'(sx_q);
          end else if (walk_k_q != cmax_q[2]) begin
            // next plane needs a fresh row base
            walk_i_q <= cmin_q[0];
            walk_j_q <= cmin_q[1];
            walk_k_q <= walk_k_q + CW'(1);
            plane_q  <= plane_q + sxsy_q;
            state_q  <= S_ROW;
          end else begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            min_x_o     <= to_field(acc_min_q[0]);
            min_y_o     <= to_field(acc_min_q[1]);
            min_z_o     <= to_field(acc_min_q[2]);
            max_x_o     <= to_field(acc_max_q[0]);
            max_y_o     <= to_field(acc_max_q[1]);
            max_z_o     <= to_field(acc_max_q[2]);
            empty_res_o <= qpres_q && !acc_occ_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  logic rd_window, walk_in_box;
  assign rd_window   = (state_q == S_ROW) || (state_q == S_WALK) || (state_q == S_DRAIN);
  assign walk_in_box = (walk_i_q >= cmin_q[0]) && (walk_i_q <= cmax_q[0]) &&
                       (walk_j_q >= cmin_q[1]) && (walk_j_q <= cmax_q[1]) &&
                       (walk_k_q >= cmin_q[2]) && (walk_k_q <= cmax_q[2]);

  // read data only comes back while a walk is running
  `GRBQ_ASSERT_IMP(a_rd_in_walk, rd_vld_q, rd_window)
  // walk coordinates stay inside the clamped box
  `GRBQ_ASSERT_IMP(a_walk_in_box, state_q == S_WALK, walk_in_box)
  // the memory never writes and reads in one cycle
  `GRBQ_ASSERT_IMP(a_no_rw_clash, wr_en, !rd_en)
  // a finished query with a free output register shows its result next cycle
  `GRBQ_ASSERT_NXT(a_done_out, state_q == S_DONE && !out_valid_q, out_valid_q && state_q == S_IDLE)

endmodule
